### design/kdsc_pkg.sv
// ----------------------------------------------------------------------------
// kdsc_pkg
// Shared types and constants of the keyboard/display scan controller.
// ----------------------------------------------------------------------------
package kdsc_pkg;

    localparam int DISPLAY_DEPTH_DEF = 16;
    localparam int FIFO_DEPTH = 8;
    localparam int SENSOR_DEPTH = 8;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [2:0] CMD_MODE     = 3'd0;
    localparam logic [2:0] CMD_CLOCK    = 3'd1;
    localparam logic [2:0] CMD_RD_FIFO  = 3'd2;
    localparam logic [2:0] CMD_RD_DISP  = 3'd3;
    localparam logic [2:0] CMD_WR_DISP  = 3'd4;
    localparam logic [2:0] CMD_MASK     = 3'd5;
    localparam logic [2:0] CMD_CLEAR    = 3'd6;
    localparam logic [2:0] CMD_END_INT  = 3'd7;

    typedef struct packed {
        logic [1:0] action;
        logic       addr_select;
        logic [7:0] write_byte;
        logic [7:0] return_lines;
        logic       shift_level;
        logic       ctrl_level;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       irq_level;
        logic [3:0] scan_lines;
        logic [7:0] display_digit;
    } t_out_item;

endpackage

### design/kdsc_if.sv
// ----------------------------------------------------------------------------
// kdsc_if
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface kdsc_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/keyboard_display_scan_controller_core.sv
// ----------------------------------------------------------------------------
// keyboard_display_scan_controller_core
// One item per cycle unless the output stalls: scan ticks and bus accesses
// update the FIFO, sensor RAM and display RAM, and a result register holds
// the reply, valid in the cycle after acceptance. An item is accepted in
// every cycle in which the result register is empty or being taken.
// ----------------------------------------------------------------------------
module keyboard_display_scan_controller_core #(
    parameter int DISPLAY_DEPTH = kdsc_pkg::DISPLAY_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    kdsc_if.sink   i_in,
    kdsc_if.source o_out
);
    localparam int FD = kdsc_pkg::FIFO_DEPTH;

    logic [4:0] r_mode, n_mode;
    logic [4:0] r_wmask, n_wmask;
    logic [7:0] r_fifo [FD], n_fifo [FD];
    logic [7:0] r_sens [8], n_sens [8];
    logic [7:0] r_disp [DISPLAY_DEPTH], n_disp [DISPLAY_DEPTH];
    logic [7:0] r_stat, n_stat;
    logic [3:0] r_dptr, n_dptr;
    logic [2:0] r_sptr, n_sptr;
    logic       r_ainc, n_ainc, r_rdd, n_rdd, r_pctrl, n_pctrl, r_sem, n_sem;
    logic [3:0] r_scan, n_scan;
    logic [5:0] r_pkey, n_pkey;
    logic [1:0] r_deb, n_deb;
    logic       r_irq, n_irq;
    logic       r_ov;
    kdsc_pkg::t_out_item r_out, n_out;

    logic accept;
    assign i_in.ready  = !r_ov || o_out.ready;
    assign accept      = i_in.valid && i_in.ready;
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    function automatic logic [3:0] didx(input logic [3:0] a);
        logic [4:0] t;
        t = {1'b0, a};
        if (t >= 5'(DISPLAY_DEPTH)) t = t - 5'(DISPLAY_DEPTH);
        return t[3:0];
    endfunction

    always_comb begin
        kdsc_pkg::t_in_item it;
        logic [7:0] rl, kd, rb, d8, fv;
        logic [2:0] addr, sz;
        logic [1:0] kind;
        logic       strobe, push, lines_m;
        logic [4:0] d;
        logic [3:0] a, m, lines;
        it = i_in.data;
        n_mode = r_mode; n_wmask = r_wmask; n_fifo = r_fifo; n_sens = r_sens;
        n_disp = r_disp; n_stat = r_stat; n_dptr = r_dptr; n_sptr = r_sptr;
        n_ainc = r_ainc; n_rdd = r_rdd; n_pctrl = r_pctrl; n_sem = r_sem;
        n_scan = r_scan; n_pkey = r_pkey; n_deb = r_deb; n_irq = r_irq;
        rb = '0; push = 1'b0; fv = '0; lines_m = 1'b0; d8 = '0;
        rl = ~it.return_lines;
        addr = r_scan[2:0];
        kd = rl & ~r_sens[addr];
        kind = r_mode[2:1];
        strobe = it.ctrl_level && !r_pctrl;
        d = it.write_byte[4:0];
        a = didx(r_dptr);
        sz = r_stat[2:0];
        if (accept) begin
            case (it.action)
                kdsc_pkg::ACT_TICK: begin
                    n_pctrl = it.ctrl_level;
                    if (kind <= 2'd1) begin
                        // Only one key can be pushed per tick: after a push
                        // the counter is zero and the next down key restarts.
                        for (int i = 0; i < 8; i++) begin
                            if (kd[i]) begin
                                if (n_deb == 2'd0) begin
                                    n_pkey = {addr, 3'(i)};
                                    n_deb = 2'd1;
                                end else if (n_pkey != {addr, 3'(i)}) begin
                                    n_deb = n_deb;
                                end else if (n_deb >= 2'd2) begin
                                    push = 1'b1;
                                    fv = {it.ctrl_level, it.shift_level, n_pkey};
                                    n_sens[addr][i] = 1'b1;
                                    n_deb = 2'd0;
                                end else begin
                                    n_deb = n_deb + 2'd1;
                                end
                            end
                        end
                        if (n_pkey[5:3] == addr && !rl[n_pkey[2:0]]) n_deb = 2'd0;
                        n_sens[addr] = n_sens[addr] & rl;
                    end else if (kind == 2'd2) begin
                        if (kd != 8'd0 && !r_sem) n_stat[6] = 1'b1;
                        if (r_sens[addr] != rl) begin
                            n_sens[addr] = rl;
                            n_irq = 1'b1;
                        end
                    end else begin
                        if (strobe) begin
                            push = 1'b1;
                            fv = rl;
                        end
                        n_sens[addr] = rl;
                    end
                    n_scan = (r_scan + 4'd1) & (r_mode[0] ? 4'd3 : 4'd15);
                end
                kdsc_pkg::ACT_READ: begin
                    if (it.addr_select) rb = r_stat;
                    else if (r_rdd) begin
                        rb = r_disp[a];
                        if (r_ainc) n_dptr = r_dptr + 4'd1;
                    end else if (r_mode[2:1] == 2'd2) begin
                        rb = r_sens[r_sptr];
                        if (r_ainc) n_sptr = r_sptr + 3'd1;
                        else n_irq = 1'b0;
                    end else begin
                        rb = r_fifo[0];
                        if (r_stat[5:3] == 3'b000) begin
                            if (sz == 3'd0) n_stat[4] = 1'b1;
                            else begin
                                for (int i = 1; i < FD; i++) n_fifo[i-1] = r_fifo[i];
                                sz = sz - 3'd1;
                                if (sz == 3'd0) n_irq = 1'b0;
                            end
                        end else if (r_stat[5:3] == 3'b101 || r_stat[5:3] == 3'b001) begin
                            for (int i = 1; i < FD; i++) n_fifo[i-1] = r_fifo[i];
                        end
                        n_stat = (n_stat & 8'hd0) | {5'd0, sz};
                    end
                end
                kdsc_pkg::ACT_WRITE: begin
                    if (it.addr_select) begin
                        case (it.write_byte[7:5])
                            kdsc_pkg::CMD_MODE: n_mode = d;
                            kdsc_pkg::CMD_RD_FIFO: begin
                                n_rdd = 1'b0;
                                if (r_mode[2:1] == 2'd2) begin
                                    n_ainc = d[4];
                                    n_sptr = d[2:0];
                                end
                            end
                            kdsc_pkg::CMD_RD_DISP: begin
                                n_rdd = 1'b1; n_dptr = d[3:0]; n_ainc = d[4];
                            end
                            kdsc_pkg::CMD_WR_DISP: begin
                                n_dptr = d[3:0]; n_ainc = d[4];
                            end
                            kdsc_pkg::CMD_MASK: n_wmask = d;
                            kdsc_pkg::CMD_CLEAR: begin
                                case (d[3:2])
                                    2'd2:    d8 = 8'h20;
                                    2'd3:    d8 = 8'hff;
                                    default: d8 = 8'h00;
                                endcase
                                if (d[4] || d[0])
                                    for (int i = 0; i < DISPLAY_DEPTH; i++) n_disp[i] = d8;
                                n_stat[7] = 1'b0;
                                n_dptr = '0;
                                if (d[1:0] != 2'd0) begin
                                    n_stat = n_stat & 8'h80;
                                    n_sptr = '0; n_deb = '0; n_irq = 1'b0;
                                end
                            end
                            kdsc_pkg::CMD_END_INT: begin
                                n_irq = 1'b0; n_sem = d[4]; n_stat[6] = 1'b0;
                            end
                            default: n_mode = r_mode;
                        endcase
                    end else if (!(r_mode[4] && r_ainc)) begin
                        if (!r_wmask[2]) n_disp[a][3:0] = it.write_byte[3:0];
                        if (!r_wmask[3]) n_disp[a][7:4] = it.write_byte[7:4];
                        if (r_ainc) n_dptr = r_dptr + 4'd1;
                    end
                end
                default: rb = '0;
            endcase
            // At most one push per item, applied to the post-read status.
            if (push && !n_stat[5] && !n_stat[6]) begin
                if (n_stat[3]) n_stat[5] = 1'b1;
                else begin
                    n_fifo[n_stat[2:0]] = fv;
                    if (n_stat[2:0] == 3'd7) n_stat[3] = 1'b1;
                    else n_stat = (n_stat & 8'he8) + {5'd0, n_stat[2:0]} + 8'd1;
                    if (n_stat[2:0] == 3'd1 && !n_stat[3]) n_irq = 1'b1;
                    if (r_stat[2:0] == 3'd0 && n_stat[3]) n_irq = 1'b1;
                end
            end
        end
        if (n_mode[0]) begin
            m = 4'd3;
            lines = ~(4'd1 << n_scan[1:0]);
        end else begin
            m = n_mode[3] ? 4'd15 : 4'd7;
            lines = n_scan;
        end
        n_out.read_byte = rb;
        n_out.irq_level = n_irq;
        n_out.scan_lines = lines;
        n_out.display_digit = n_disp[didx(n_scan & m)];
        lines_m = 1'b0;
        n_out.read_byte = rb | {7'd0, lines_m};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 5'd8; r_wmask <= '0; r_stat <= '0; r_dptr <= '0;
            r_sptr <= '0; r_ainc <= 1'b1; r_rdd <= 1'b0; r_pctrl <= 1'b1;
            r_sem <= 1'b0; r_scan <= '0; r_pkey <= '0; r_deb <= '0;
            r_irq <= 1'b0; r_ov <= 1'b0;
            for (int i = 0; i < FD; i++) r_fifo[i] <= '0;
            for (int i = 0; i < 8; i++) r_sens[i] <= '0;
            for (int i = 0; i < DISPLAY_DEPTH; i++) r_disp[i] <= '0;
        end else begin
            r_mode <= n_mode; r_wmask <= n_wmask; r_stat <= n_stat;
            r_dptr <= n_dptr; r_sptr <= n_sptr; r_ainc <= n_ainc; r_rdd <= n_rdd;
            r_pctrl <= n_pctrl; r_sem <= n_sem; r_scan <= n_scan; r_pkey <= n_pkey;
            r_deb <= n_deb; r_irq <= n_irq;
            r_fifo <= n_fifo; r_sens <= n_sens; r_disp <= n_disp;
            if (accept) r_ov <= 1'b1;
            else if (o_out.ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_out <= n_out;
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !o_out.ready |=> r_ov && $stable(r_out))
        else $error("result changed while stalled");
    a_stat7: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_stat[7]) else $error("status bit 7 set");
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stat[3] |-> r_stat[2:0] == 3'd7) else $error("full with short count");
endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyboard/display scan controller: a directed
// table of scan ticks and bus accesses, then random command sequences with
// random bursts and receiver stalls, each result checked against a predictor.
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;

    kdsc_if #(.T(kdsc_pkg::t_in_item))  in_ch ();
    kdsc_if #(.T(kdsc_pkg::t_out_item)) out_ch ();

    keyboard_display_scan_controller_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // Predictor state.
    logic [4:0] p_mode;
    logic [4:0] p_mask;
    logic [7:0] p_fifo [kdsc_pkg::FIFO_DEPTH];
    logic [7:0] p_sensor [kdsc_pkg::SENSOR_DEPTH];
    logic [7:0] p_disp [16];
    logic [7:0] p_status;
    logic [3:0] p_dptr;
    logic [2:0] p_sptr;
    logic       p_ainc;
    logic       p_rdisp;
    logic [3:0] p_scan;
    logic       p_prev_ctrl;
    logic       p_sem;
    logic [5:0] p_pend;
    logic [1:0] p_deb;
    logic       p_irq;

    kdsc_pkg::t_out_item reply_queue [$];
    int         fail_count;
    int         checked_count;
    int         items_total;
    int         ticks_sent;
    int         reads_sent;
    int         writes_sent;
    bit         stim_done;
    bit         long_hold;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void model_reset();
        p_mode = 5'd8;
        p_mask = '0;
        foreach (p_fifo[i]) p_fifo[i] = '0;
        foreach (p_sensor[i]) p_sensor[i] = '0;
        foreach (p_disp[i]) p_disp[i] = '0;
        p_status = '0;
        p_dptr = '0;
        p_sptr = '0;
        p_ainc = 1'b1;
        p_rdisp = 1'b0;
        p_scan = '0;
        p_prev_ctrl = 1'b1;
        p_sem = 1'b0;
        p_pend = '0;
        p_deb = '0;
        p_irq = 1'b0;
    endfunction

    // DISPLAY_DEPTH is 16, so a 4-bit address needs no wrap.
    function automatic void key_push(input logic [7:0] v);
        int size;
        size = p_status[2:0];
        if (p_status[5] || p_status[6]) return;
        if (p_status[3]) begin
            p_status[5] = 1'b1;
            return;
        end
        p_fifo[size] = v;
        if (size == 7) p_status[3] = 1'b1;
        else p_status = (p_status & 8'he8) + 8'(size + 1);
        if (size == 0) p_irq = 1'b1;
    endfunction

    function automatic void fifo_advance();
        for (int i = 1; i < kdsc_pkg::FIFO_DEPTH; i++) p_fifo[i-1] = p_fifo[i];
    endfunction

    function automatic void do_tick(input logic [7:0] raw, input logic shf,
                                    input logic ctl);
        logic [7:0] rl;
        logic [2:0] row;
        logic [7:0] down;
        logic       strobe;
        logic [5:0] code;
        rl = ~raw;
        row = p_scan[2:0];
        down = rl & ~p_sensor[row];
        strobe = ctl && !p_prev_ctrl;
        p_prev_ctrl = ctl;
        if (p_mode[2:1] <= 2'd1) begin
            for (int i = 0; i < 8; i++) begin
                code = {row, 3'(i)};
                if (!down[i]) continue;
                if (p_deb == 2'd0) begin
                    p_pend = code;
                    p_deb = 2'd1;
                end else if (p_pend != code) begin
                end else if (p_deb >= 2'd2) begin
                    key_push({ctl, shf, p_pend});
                    p_sensor[row][i] = 1'b1;
                    p_deb = 2'd0;
                end else begin
                    p_deb = p_deb + 2'd1;
                end
            end
            if (p_pend[5:3] == row && !rl[p_pend[2:0]]) p_deb = 2'd0;
            p_sensor[row] = p_sensor[row] & rl;
        end else if (p_mode[2:1] == 2'd2) begin
            if (down != 8'd0 && !p_sem) p_status[6] = 1'b1;
            if (p_sensor[row] != rl) begin
                p_sensor[row] = rl;
                p_irq = 1'b1;
            end
        end else begin
            if (strobe) key_push(rl);
            p_sensor[row] = rl;
        end
        p_scan = p_mode[0] ? ((p_scan + 4'd1) & 4'd3) : (p_scan + 4'd1);
    endfunction

    function automatic logic [7:0] data_port_read();
        logic [7:0] d;
        int size;
        if (p_rdisp) begin
            d = p_disp[p_dptr];
            if (p_ainc) p_dptr = p_dptr + 4'd1;
        end else if (p_mode[2:1] == 2'd2) begin
            d = p_sensor[p_sptr];
            if (p_ainc) p_sptr = p_sptr + 3'd1;
            else p_irq = 1'b0;
        end else begin
            size = p_status[2:0];
            d = p_fifo[0];
            case (p_status & 8'h38)
                8'h00: begin
                    if (size == 0) p_status[4] = 1'b1;
                    else begin
                        fifo_advance();
                        size--;
                        if (size == 0) p_irq = 1'b0;
                    end
                end
                8'h28, 8'h08: fifo_advance();
                default: ;
            endcase
            p_status = (p_status & 8'hd0) | 8'(size);
        end
        return d;
    endfunction

    function automatic void do_command(input logic [7:0] b);
        logic [4:0] d;
        logic [7:0] fill;
        d = b[4:0];
        case (b[7:5])
            kdsc_pkg::CMD_MODE: p_mode = d;
            kdsc_pkg::CMD_RD_FIFO: begin
                p_rdisp = 1'b0;
                if (p_mode[2:1] == 2'd2) begin
                    p_ainc = d[4];
                    p_sptr = d[2:0];
                end
            end
            kdsc_pkg::CMD_RD_DISP: begin
                p_rdisp = 1'b1;
                p_dptr = d[3:0];
                p_ainc = d[4];
            end
            kdsc_pkg::CMD_WR_DISP: begin
                p_dptr = d[3:0];
                p_ainc = d[4];
            end
            kdsc_pkg::CMD_MASK: p_mask = d;
            kdsc_pkg::CMD_CLEAR: begin
                fill = (d[3:2] == 2'd2) ? 8'h20 : (d[3:2] == 2'd3) ? 8'hff : 8'h00;
                if (d[0] || d[4]) foreach (p_disp[i]) p_disp[i] = fill;
                p_status[7] = 1'b0;
                p_dptr = '0;
                if (d[1:0] != 2'd0) begin
                    p_status = p_status & 8'h80;
                    p_sptr = '0;
                    p_deb = '0;
                    p_irq = 1'b0;
                end
            end
            kdsc_pkg::CMD_END_INT: begin
                p_irq = 1'b0;
                p_sem = d[4];
                p_status[6] = 1'b0;
            end
            default: ;
        endcase
    endfunction

    function automatic void data_port_write(input logic [7:0] b);
        if (p_mode[4] && p_ainc) return;
        if (!p_mask[2]) p_disp[p_dptr][3:0] = b[3:0];
        if (!p_mask[3]) p_disp[p_dptr][7:4] = b[7:4];
        if (p_ainc) p_dptr = p_dptr + 4'd1;
    endfunction

    function automatic kdsc_pkg::t_out_item predict_reply(input kdsc_pkg::t_in_item it);
        kdsc_pkg::t_out_item r;
        logic [3:0] idx;
        r.read_byte = '0;
        if (it.action == kdsc_pkg::ACT_TICK) begin
            do_tick(it.return_lines, it.shift_level, it.ctrl_level);
        end else if (it.action == kdsc_pkg::ACT_READ) begin
            r.read_byte = it.addr_select ? p_status : data_port_read();
        end else if (it.action == kdsc_pkg::ACT_WRITE) begin
            if (it.addr_select) do_command(it.write_byte);
            else data_port_write(it.write_byte);
        end
        if (p_mode[0]) begin
            idx = p_scan & 4'd3;
            r.scan_lines = ~(4'd1 << p_scan[1:0]);
        end else begin
            idx = p_scan & (p_mode[3] ? 4'd15 : 4'd7);
            r.scan_lines = p_scan;
        end
        r.irq_level = p_irq;
        r.display_digit = p_disp[idx];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch in %s: got %0h, expected %0h (reply %0d)",
                 what, got, want, checked_count);
        fail_count++;
    endtask

    // Directed table. A known reply is typed in where it is plain; others
    // fall back on the predictor.
    typedef struct {
        kdsc_pkg::t_in_item  item;
        bit                  known;
        kdsc_pkg::t_out_item reply;
    } t_row;

    function automatic kdsc_pkg::t_in_item mk(input logic [1:0] a, input logic s,
                                              input logic [7:0] wb, input logic [7:0] rl,
                                              input logic sh, input logic ct);
        kdsc_pkg::t_in_item it;
        it.action = a; it.addr_select = s; it.write_byte = wb;
        it.return_lines = rl; it.shift_level = sh; it.ctrl_level = ct;
        return it;
    endfunction

    t_row dir_rows [$];
    kdsc_pkg::t_in_item send_queue [$];

    task automatic build_directed();
        t_row r;
        // Status after reset, then an underrun FIFO read.
        r.known = 1; r.item = mk(kdsc_pkg::ACT_READ, 1, 8'h00, 8'hff, 0, 0);
        r.reply = '{read_byte: 8'h00, irq_level: 0, scan_lines: 4'd0, display_digit: 8'h00};
        dir_rows.push_back(r);
        r.item = mk(kdsc_pkg::ACT_READ, 0, 8'h00, 8'hff, 0, 0);
        r.reply = '{read_byte: 8'h00, irq_level: 0, scan_lines: 4'd0, display_digit: 8'h00};
        dir_rows.push_back(r);
        r.item = mk(kdsc_pkg::ACT_READ, 1, 8'h00, 8'hff, 0, 0);
        r.reply = '{read_byte: 8'h10, irq_level: 0, scan_lines: 4'd0, display_digit: 8'h00};
        dir_rows.push_back(r);
        r.item = mk(kdsc_pkg::ACT_NONE, 1, 8'hff, 8'h00, 1, 1);
        r.reply = '{read_byte: 8'h00, irq_level: 0, scan_lines: 4'd0, display_digit: 8'h00};
        dir_rows.push_back(r);
        r.known = 0;
        // Clear display to all ones, masked write, clock command, wrap address.
        r.item = mk(kdsc_pkg::ACT_WRITE, 1, {kdsc_pkg::CMD_CLEAR, 5'b01101}, 0, 0, 0);
        dir_rows.push_back(r);
        r.item = mk(kdsc_pkg::ACT_WRITE, 1, {kdsc_pkg::CMD_CLOCK, 5'h1f}, 0, 0, 0);
        dir_rows.push_back(r);
        r.item = mk(kdsc_pkg::ACT_WRITE, 1, {kdsc_pkg::CMD_MASK, 5'h04}, 0, 0, 0);
        dir_rows.push_back(r);
        r.item = mk(kdsc_pkg::ACT_WRITE, 1, {kdsc_pkg::CMD_WR_DISP, 5'h1f}, 0, 0, 0);
        dir_rows.push_back(r);
        r.item = mk(kdsc_pkg::ACT_WRITE, 0, 8'h5a, 0, 0, 0); dir_rows.push_back(r);
        r.item = mk(kdsc_pkg::ACT_WRITE, 0, 8'h00, 0, 0, 0); dir_rows.push_back(r);
        // Right entry with autoincrement ignores the data write.
        r.item = mk(kdsc_pkg::ACT_WRITE, 1, {kdsc_pkg::CMD_MODE, 5'h18}, 0, 0, 0);
        dir_rows.push_back(r);
        r.item = mk(kdsc_pkg::ACT_WRITE, 0, 8'h33, 0, 0, 0); dir_rows.push_back(r);
        r.item = mk(kdsc_pkg::ACT_WRITE, 1, {kdsc_pkg::CMD_RD_DISP, 5'h1f}, 0, 0, 0);
        dir_rows.push_back(r);
        r.item = mk(kdsc_pkg::ACT_READ, 0, 0, 0, 0, 0); dir_rows.push_back(r);
        // Key debounce: hold one key for three ticks of the same row.
        r.item = mk(kdsc_pkg::ACT_WRITE, 1, {kdsc_pkg::CMD_MODE, 5'h01}, 0, 0, 0);
        dir_rows.push_back(r);
        r.item = mk(kdsc_pkg::ACT_WRITE, 1, {kdsc_pkg::CMD_RD_FIFO, 5'h00}, 0, 0, 0);
        dir_rows.push_back(r);
        for (int i = 0; i < 12; i++) begin
            r.item = mk(kdsc_pkg::ACT_TICK, 0, 0, 8'hfe, 1, 0); dir_rows.push_back(r);
        end
        // Sensor mode with a closure, then strobed mode with an edge.
        r.item = mk(kdsc_pkg::ACT_WRITE, 1, {kdsc_pkg::CMD_MODE, 5'h04}, 0, 0, 0);
        dir_rows.push_back(r);
        r.item = mk(kdsc_pkg::ACT_TICK, 0, 0, 8'h00, 0, 0); dir_rows.push_back(r);
        r.item = mk(kdsc_pkg::ACT_READ, 0, 0, 0, 0, 0); dir_rows.push_back(r);
        r.item = mk(kdsc_pkg::ACT_WRITE, 1, {kdsc_pkg::CMD_END_INT, 5'h10}, 0, 0, 0);
        dir_rows.push_back(r);
        r.item = mk(kdsc_pkg::ACT_WRITE, 1, {kdsc_pkg::CMD_MODE, 5'h06}, 0, 0, 0);
        dir_rows.push_back(r);
        r.item = mk(kdsc_pkg::ACT_TICK, 0, 0, 8'h00, 0, 0); dir_rows.push_back(r);
        r.item = mk(kdsc_pkg::ACT_TICK, 0, 0, 8'h81, 0, 1); dir_rows.push_back(r);
        r.item = mk(kdsc_pkg::ACT_READ, 0, 0, 0, 0, 0); dir_rows.push_back(r);
    endtask

    // Random item with weighted actions; content is random, with ticks and mode commands biased.
    function automatic kdsc_pkg::t_in_item rand_item();
        kdsc_pkg::t_in_item it;
        int sel;
        logic [2:0] cmd;
        it = mk(kdsc_pkg::ACT_TICK, 1'($urandom), 8'($urandom), 8'($urandom),
                1'($urandom), 1'($urandom));
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            it.action = kdsc_pkg::ACT_TICK;
            // Mostly a single key or nothing, so debouncing gets through.
            case ($urandom_range(0, 3))
                0: it.return_lines = 8'hff;
                1, 2: it.return_lines = ~(8'd1 << $urandom_range(0, 2));
                default: ;
            endcase
        end else if (sel < 70) begin
            it.action = kdsc_pkg::ACT_READ;
        end else if (sel < 97) begin
            it.action = kdsc_pkg::ACT_WRITE;
            if (it.addr_select) begin
                cmd = 3'($urandom);
                if (cmd == kdsc_pkg::CMD_MODE && $urandom_range(0, 1))
                    it.write_byte[4] = 1'b0;
                it.write_byte[7:5] = cmd;
            end
        end else begin
            it.action = kdsc_pkg::ACT_NONE;
        end
        return it;
    endfunction

    // Sender: bursts and gaps; hold-off of the receiver runs elsewhere.
    initial begin
        int burst;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        fail_count = 0;
        checked_count = 0;
        ticks_sent = 0; reads_sent = 0; writes_sent = 0;
        stim_done = 0;
        model_reset();
        build_directed();
        foreach (dir_rows[i]) send_queue.push_back(dir_rows[i].item);
        for (int i = 0; i < 700; i++) send_queue.push_back(rand_item());
        items_total = send_queue.size();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (send_queue.size() > 0) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && send_queue.size() > 0) begin
                in_ch.valid <= 1'b1;
                in_ch.data <= send_queue[0];
                @(posedge i_clk);
                if (in_ch.ready) begin
                    void'(send_queue.pop_front());
                    burst--;
                end
            end
            if ($urandom_range(0, 2) == 0 && send_queue.size() > 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        in_ch.valid <= 1'b0;
        stim_done = 1;
    end

    // Prediction on acceptance.
    int dir_index = 0;
    kdsc_pkg::t_out_item known_replies [$];
    bit        known_flags [$];
    always @(posedge i_clk) begin
        kdsc_pkg::t_out_item r;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            r = predict_reply(in_ch.data);
            case (in_ch.data.action)
                kdsc_pkg::ACT_TICK: ticks_sent++;
                kdsc_pkg::ACT_READ: reads_sent++;
                kdsc_pkg::ACT_WRITE: writes_sent++;
                default: ;
            endcase
            if (dir_index < dir_rows.size()) begin
                known_flags.push_back(dir_rows[dir_index].known);
                known_replies.push_back(dir_rows[dir_index].reply);
                dir_index++;
            end else begin
                known_flags.push_back(0);
                known_replies.push_back(r);
            end
            reply_queue.push_back(r);
        end
    end

    // Receiver: its own stall pattern, with one long hold-off early on.
    int rx_phase = 0;
    initial begin
        out_ch.ready = 1'b0;
        long_hold = 0;
        @(posedge i_rst_n);
        repeat (60) @(posedge i_clk);
        long_hold = 1;
        out_ch.ready <= 1'b0;
        repeat (40) @(posedge i_clk);
        long_hold = 0;
        forever begin
            rx_phase++;
            if ((rx_phase / 64) % 3 == 0) out_ch.ready <= 1'b1;
            else out_ch.ready <= ($urandom_range(0, 3) != 0);
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        kdsc_pkg::t_out_item want;
        bit known;
        kdsc_pkg::t_out_item typed;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (reply_queue.size() == 0) begin
                report_mismatch("unexpected reply", int'(out_ch.data), 0);
            end else begin
                want = reply_queue.pop_front();
                known = known_flags.pop_front();
                typed = known_replies.pop_front();
                if (known) want = typed;
                if (out_ch.data.read_byte !== want.read_byte)
                    report_mismatch("read_byte", out_ch.data.read_byte, want.read_byte);
                if (out_ch.data.irq_level !== want.irq_level)
                    report_mismatch("irq_level", out_ch.data.irq_level, want.irq_level);
                if (out_ch.data.scan_lines !== want.scan_lines)
                    report_mismatch("scan_lines", out_ch.data.scan_lines, want.scan_lines);
                if (out_ch.data.display_digit !== want.display_digit)
                    report_mismatch("display_digit", out_ch.data.display_digit,
                                    want.display_digit);
                checked_count++;
            end
        end
    end

    // Watchdog and end of run.
    initial begin
        int idle;
        idle = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || long_hold)
                idle = 0;
            else
                idle++;
            if (stim_done && checked_count == items_total) begin
                repeat (5) @(posedge i_clk);
                $display("run covered %0d scan ticks, %0d reads, %0d writes; %0d replies checked",
                         ticks_sent, reads_sent, writes_sent, checked_count);
                if (fail_count == 0 && reply_queue.size() == 0) $display("CHECK OK");
                else $display("CHECK FAILED");
                $finish;
            end else if (idle >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d replies outstanding", reply_queue.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule
